>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line editor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ffle_pkg.sv
// ----------------------------------------------------------------------------
// Fixed field line editor package
// Widths, codes, command structs and character classes shared by the RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package ffle_pkg;

   localparam int MAX_LEN = 32;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // fixed field widths
   localparam int REQ_W   = 2;
   localparam int LIDX_W  = 5;
   localparam int CHAR_W  = 8;
   localparam int CUR_W   = 6;
   localparam int KIND_W  = 4;
   localparam int CODE_W  = 10;
   localparam int FLEN_W  = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 6;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // request types
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd1;
   localparam logic [REQ_W-1:0] REQ_KEY   = 2'd2;

   // key kinds
   localparam logic [KIND_W-1:0] KEY_CHAR    = 4'd0;
   localparam logic [KIND_W-1:0] KEY_END     = 4'd1;
   localparam logic [KIND_W-1:0] KEY_HOME    = 4'd2;
   localparam logic [KIND_W-1:0] KEY_TAB     = 4'd3;
   localparam logic [KIND_W-1:0] KEY_LEFT    = 4'd4;
   localparam logic [KIND_W-1:0] KEY_RIGHT   = 4'd5;
   localparam logic [KIND_W-1:0] KEY_DELETE  = 4'd6;
   localparam logic [KIND_W-1:0] KEY_RUBLINE = 4'd7;
   localparam logic [KIND_W-1:0] KEY_RUBWORD = 4'd8;
   localparam logic [KIND_W-1:0] KEY_RESTORE = 4'd9;
   localparam logic [KIND_W-1:0] KEY_EXIT    = 4'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEYPUNCH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_END_SCAN,
      ST_WORD_SCAN,
      ST_SHIFT,
      ST_RESULT,
      ST_BURST
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_COPY,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_op_type;

   // broadcast to the whole row
   typedef struct packed {
      cell_op_type        op;
      logic [CNT_W-1:0]   pos;
      logic [CNT_W-1:0]   lo;
      logic [CNT_W-1:0]   len;
      logic [CHAR_W-1:0]  ch;
      logic               clr;
   } cell_cmd_type;

   // per-cell decode of the broadcast
   typedef struct packed {
      logic in_field;
      logic sel;
      logic hit;
      logic last;
   } cell_ctl_type;

   function automatic logic is_printable(input logic [CHAR_W-1:0] c);
      return !((c < 8'd32) || ((c >= 8'd127) && (c < 8'd160)) || (c == 8'd255));
   endfunction

   function automatic logic is_mark(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == 8'h2c) || (c == 8'h2e) || (c == 8'h21) ||
             (c == 8'h3f) || (c == 8'h3b) || (c == 8'h3a);
   endfunction

endpackage

`default_nettype wire

>>> rtl/ffle_if.sv
// ----------------------------------------------------------------------------
// Line editor channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffle_req_if;
   logic                            valid;
   logic                            ready;
   logic [ffle_pkg::REQ_W-1:0]      req_type;
   logic [ffle_pkg::LIDX_W-1:0]     load_index;
   logic [ffle_pkg::CHAR_W-1:0]     default_char;
   logic [ffle_pkg::CUR_W-1:0]      start_cursor;
   logic                            blank_on_first;
   logic [ffle_pkg::KIND_W-1:0]     key_kind;
   logic [ffle_pkg::CHAR_W-1:0]     key_char;
   logic [ffle_pkg::CODE_W-1:0]     exit_code;

   modport source (
      output valid, req_type, load_index, default_char, start_cursor,
             blank_on_first, key_kind, key_char, exit_code,
      input  ready
   );
   modport sink (
      input  valid, req_type, load_index, default_char, start_cursor,
             blank_on_first, key_kind, key_char, exit_code,
      output ready
   );
endinterface

interface ffle_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            bell;
   logic [ffle_pkg::CUR_W-1:0]      cursor_pos;
   logic                            edit_done;
   logic [ffle_pkg::CODE_W-1:0]     done_code;
   logic [ffle_pkg::CHAR_W-1:0]     field_char;
   logic                            last_result;

   modport source (
      output valid, bell, cursor_pos, edit_done, done_code, field_char, last_result,
      input  ready
   );
   modport sink (
      input  valid, bell, cursor_pos, edit_done, done_code, field_char, last_result,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/fixed_field_line_editor_unit.sv
// Flow: one request at a time; end scans back over trailing spaces, rub-line and
//   rub-word shift the field left, and rub-word first scans back to a word mark.
//   A final field burst gives field_length words, one per cycle while the sink is ready.
// Reset: synchronous, active high; field all spaces, cursor 0, field_length 32,
//   modes off; the default store holds nothing until loaded.
// ----------------------------------------------------------------------------
// Fixed field line editor
// Sequencer plus a row of character cells that shift and rotate the field.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_field_line_editor_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [ffle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ffle_pkg::CSR_DAT_W-1:0]     csr_wdata,
   ffle_req_if.sink                                req_if,
   ffle_rsp_if.source                              rsp_if
);
   import ffle_pkg::*;

   cell_cmd_type                       cell_cmd;
   logic [MAX_LEN-1:0][CHAR_W-1:0]     cell_chars;

   ffle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .cell_chars (cell_chars),
      .cell_cmd   (cell_cmd)
   );

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      cell_ctl_type      ctl;
      logic [CHAR_W-1:0] left_char;
      logic [CHAR_W-1:0] right_char;

      assign ctl.in_field = (CNT_W'(i) < cell_cmd.len);
      assign ctl.sel      = (CNT_W'(i) >= cell_cmd.lo) && (CNT_W'(i) < cell_cmd.len);
      assign ctl.hit      = (CNT_W'(i) == cell_cmd.pos);
      assign ctl.last     = (CNT_W'(i) == (cell_cmd.len - 1'b1));

      if (i == 0) begin : g_left_edge
         assign left_char = CHAR_SPACE;
      end else begin : g_left
         assign left_char = cell_chars[i-1];
      end

      if (i == MAX_LEN - 1) begin : g_right_edge
         assign right_char = CHAR_SPACE;
      end else begin : g_right
         assign right_char = cell_chars[i+1];
      end

      ffle_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .ctl        (ctl),
         .left_char  (left_char),
         .right_char (right_char),
         .first_char (cell_chars[0]),
         .edit_char  (cell_chars[i])
      );
   end

endmodule

`default_nettype wire

>>> rtl/ffle_cell.sv
// ----------------------------------------------------------------------------
// Line editor cell
// One field position: edit character and default character, fed by neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module ffle_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ffle_pkg::cell_cmd_type        cmd,
   input  wire ffle_pkg::cell_ctl_type        ctl,
   input  wire logic [ffle_pkg::CHAR_W-1:0]   left_char,
   input  wire logic [ffle_pkg::CHAR_W-1:0]   right_char,
   input  wire logic [ffle_pkg::CHAR_W-1:0]   first_char,
   output      logic [ffle_pkg::CHAR_W-1:0]   edit_char
);
   import ffle_pkg::*;

   logic [CHAR_W-1:0] edit_ff, edit_in;
   logic [CHAR_W-1:0] def_ff, def_in;

   always_comb begin
      edit_in = edit_ff;
      def_in  = def_ff;
      case (cmd.op)
         CELL_LOAD: begin
            if (ctl.hit) def_in = cmd.ch;
         end
         CELL_COPY: begin
            if (ctl.in_field) edit_in = def_ff;
         end
         CELL_INSERT: begin
            // place the character at the cursor; when armed blank the rest of the field, else open a gap
            if (ctl.hit && ctl.in_field) begin
               edit_in = cmd.ch;
            end else if (ctl.sel) begin
               edit_in = cmd.clr ? CHAR_SPACE : left_char;
            end else if (cmd.clr && ctl.in_field) begin
               edit_in = CHAR_SPACE;
            end
         end
         CELL_SHIFT: begin
            if (ctl.sel) edit_in = ctl.last ? CHAR_SPACE : right_char;
         end
         CELL_ROTATE: begin
            if (ctl.in_field) edit_in = ctl.last ? first_char : right_char;
         end
         default: begin
            edit_in = edit_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edit_ff <= CHAR_SPACE;
      end else begin
         edit_ff <= edit_in;
      end
   end

   always_ff @(posedge clock) begin
      def_ff <= def_in;
   end

   assign edit_char = edit_ff;

endmodule

`default_nettype wire

>>> rtl/ffle_ctrl.sv
// ----------------------------------------------------------------------------
// Line editor sequencer
// Decodes requests and keys, drives the cell row, scans and emits results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ffle_ctrl (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic                                             csr_we,
   input  wire logic [ffle_pkg::CSR_IDX_W-1:0]                   csr_index,
   input  wire logic [ffle_pkg::CSR_DAT_W-1:0]                   csr_wdata,
   ffle_req_if.sink                                              req_if,
   ffle_rsp_if.source                                            rsp_if,
   input  wire logic [ffle_pkg::MAX_LEN-1:0][ffle_pkg::CHAR_W-1:0] cell_chars,
   output      ffle_pkg::cell_cmd_type                           cell_cmd
);
   import ffle_pkg::*;

   state_type state_ff, state_in;

   logic [FLEN_W-1:0] field_len_ff;
   logic              keypunch_ff;
   logic              upper_ff;

   logic [CNT_W-1:0]  cursor_ff, cursor_in;
   logic              clear_ff, clear_in;
   logic [CUR_W-1:0]  start_ff, start_in;
   logic              blank_ff, blank_in;
   logic              bell_ff, bell_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;

   logic [CNT_W-1:0]  len;
   logic [CNT_W-1:0]  cur;
   logic              req_fire;
   logic              rsp_fire;
   logic              print;
   logic [CHAR_W-1:0] ch_up;
   logic              ins_full;
   logic [CNT_W-1:0]  ins_cur;
   logic              kp_done;
   logic [CNT_W-1:0]  begin_cur;
   logic [CNT_W-1:0]  restore_cur;
   logic [CNT_W-1:0]  scan_ptr;
   logic [CHAR_W-1:0] scan_char;
   logic              end_step;
   logic              word_step;
   logic [CNT_W-1:0]  word_cnt;
   logic              burst_last;

   // field length used clamped to 1..MAX_LEN
   always_comb begin
      if (field_len_ff == '0) begin
         len = CNT_W'(1);
      end else if (int'(field_len_ff) > MAX_LEN) begin
         len = CNT_W'(MAX_LEN);
      end else begin
         len = CNT_W'(field_len_ff);
      end
   end

   assign cur       = (cursor_ff > len) ? len : cursor_ff;
   assign req_fire  = req_if.valid && req_if.ready;
   assign rsp_fire  = rsp_if.valid && rsp_if.ready;
   assign print     = is_printable(req_if.key_char);
   assign ch_up     = (upper_ff && (req_if.key_char >= 8'h61) && (req_if.key_char <= 8'h7a))
                      ? (req_if.key_char - 8'h20) : req_if.key_char;
   assign ins_full  = (cur >= len);
   assign ins_cur   = ins_full ? cur : (cur + 1'b1);
   assign kp_done   = (ins_cur >= len) && keypunch_ff;
   assign begin_cur = req_if.blank_on_first ? '0 :
                      ((int'(req_if.start_cursor) > int'(len)) ? len
                                                               : CNT_W'(req_if.start_cursor));
   assign restore_cur = blank_ff ? '0 :
                        ((int'(start_ff) > int'(len)) ? len : CNT_W'(start_ff));

   // end scan looks left of the cursor, word scan at the stop position
   assign scan_ptr   = (state_ff == ST_END_SCAN) ? (cursor_ff - 1'b1) : ptr_ff;
   assign scan_char  = cell_chars[scan_ptr[IDX_W-1:0]];
   assign end_step   = (cursor_ff != '0) && (scan_char == CHAR_SPACE);
   assign word_step  = (ptr_ff != '0) && !is_mark(scan_char);
   assign word_cnt   = cursor_ff - 1'b1 - ptr_ff;
   assign burst_last = (cnt_ff == (len - 1'b1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.req_type)
                  REQ_LOAD:  state_in = ST_IDLE;
                  REQ_BEGIN: state_in = ST_RESULT;
                  REQ_KEY: begin
                     case (req_if.key_kind)
                        KEY_CHAR: begin
                           if (!print || kp_done) state_in = ST_BURST;
                           else                   state_in = ST_RESULT;
                        end
                        KEY_END:     state_in = ST_END_SCAN;
                        KEY_HOME, KEY_TAB, KEY_LEFT, KEY_RIGHT, KEY_DELETE,
                        KEY_RESTORE: state_in = ST_RESULT;
                        KEY_RUBLINE: state_in = (cur == '0) ? ST_RESULT : ST_SHIFT;
                        KEY_RUBWORD: state_in = (cur == '0) ? ST_RESULT : ST_WORD_SCAN;
                        KEY_EXIT:    state_in = ST_BURST;
                        default:     state_in = ST_BURST;
                     endcase
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_END_SCAN: begin
            if (!end_step) state_in = ST_RESULT;
         end
         ST_WORD_SCAN: begin
            if (!word_step) state_in = (word_cnt == '0) ? ST_RESULT : ST_SHIFT;
         end
         ST_SHIFT: begin
            if (cnt_ff == CNT_W'(1)) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_fire) state_in = ST_IDLE;
         end
         ST_BURST: begin
            if (rsp_fire && burst_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // editing state and result fields
   always_comb begin
      cursor_in = cursor_ff;
      clear_in  = clear_ff;
      start_in  = start_ff;
      blank_in  = blank_ff;
      bell_in   = bell_ff;
      code_in   = code_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      lo_in     = lo_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.req_type == REQ_BEGIN)) begin
               start_in  = req_if.start_cursor;
               blank_in  = req_if.blank_on_first;
               clear_in  = req_if.blank_on_first;
               cursor_in = begin_cur;
               bell_in   = 1'b0;
            end else if (req_fire && (req_if.req_type == REQ_KEY)) begin
               clear_in  = 1'b0;
               cursor_in = cur;
               bell_in   = 1'b0;
               code_in   = '0;
               cnt_in    = '0;
               case (req_if.key_kind)
                  KEY_CHAR: begin
                     if (!print) begin
                        code_in = req_if.exit_code;
                     end else begin
                        bell_in   = ins_full;
                        cursor_in = ins_cur;
                     end
                  end
                  KEY_END:  cursor_in = len;
                  KEY_HOME: cursor_in = '0;
                  KEY_TAB:  bell_in = 1'b1;
                  KEY_LEFT: begin
                     if (cur == '0) bell_in = 1'b1;
                     else           cursor_in = cur - 1'b1;
                  end
                  KEY_RIGHT: begin
                     if (cur >= len) bell_in = 1'b1;
                     else            cursor_in = cur + 1'b1;
                  end
                  KEY_DELETE: begin
                     if (cur != '0) cursor_in = cur - 1'b1;
                  end
                  KEY_RUBLINE: begin
                     cursor_in = '0;
                     cnt_in    = cur;
                     lo_in     = '0;
                  end
                  KEY_RUBWORD: begin
                     if (cur == '0) bell_in = 1'b1;
                     else           ptr_in  = cur - 1'b1;
                  end
                  KEY_RESTORE: begin
                     clear_in  = blank_ff;
                     cursor_in = restore_cur;
                  end
                  KEY_EXIT: code_in = req_if.exit_code;
                  default:  code_in = req_if.exit_code;
               endcase
            end
         end
         ST_END_SCAN: begin
            if (end_step) cursor_in = cursor_ff - 1'b1;
         end
         ST_WORD_SCAN: begin
            if (word_step) begin
               ptr_in = ptr_ff - 1'b1;
            end else begin
               cnt_in    = word_cnt;
               lo_in     = ptr_ff + 1'b1;
               cursor_in = ptr_ff;
            end
         end
         ST_SHIFT: begin
            cnt_in = cnt_ff - 1'b1;
         end
         ST_BURST: begin
            if (rsp_fire) cnt_in = cnt_ff + 1'b1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // outputs: handshake, result word and row command
   always_comb begin
      req_if.ready       = (state_ff == ST_IDLE);
      rsp_if.valid       = (state_ff == ST_RESULT) || (state_ff == ST_BURST);
      rsp_if.bell        = bell_ff;
      rsp_if.cursor_pos  = CUR_W'(cursor_ff);
      rsp_if.edit_done   = (state_ff == ST_BURST);
      rsp_if.done_code   = (state_ff == ST_BURST) ? code_ff : '0;
      rsp_if.field_char  = (state_ff == ST_BURST) ? cell_chars[0] : '0;
      rsp_if.last_result = (state_ff == ST_RESULT) || burst_last;

      cell_cmd     = '0;
      cell_cmd.op  = CELL_HOLD;
      cell_cmd.len = len;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.req_type == REQ_LOAD)) begin
               cell_cmd.op  = CELL_LOAD;
               cell_cmd.pos = CNT_W'(req_if.load_index);
               cell_cmd.ch  = req_if.default_char;
            end else if (req_fire && (req_if.req_type == REQ_BEGIN)) begin
               cell_cmd.op = CELL_COPY;
            end else if (req_fire && (req_if.req_type == REQ_KEY)) begin
               if ((req_if.key_kind == KEY_CHAR) && print) begin
                  cell_cmd.op  = CELL_INSERT;
                  cell_cmd.pos = cur;
                  cell_cmd.lo  = ins_full ? len : (cur + 1'b1);
                  cell_cmd.ch  = ch_up;
                  cell_cmd.clr = clear_ff;
               end else if ((req_if.key_kind == KEY_DELETE) && (cur != '0)) begin
                  cell_cmd.op = CELL_SHIFT;
                  cell_cmd.lo = cur - 1'b1;
               end else if (req_if.key_kind == KEY_RESTORE) begin
                  cell_cmd.op = CELL_COPY;
               end
            end
         end
         ST_SHIFT: begin
            cell_cmd.op = CELL_SHIFT;
            cell_cmd.lo = lo_ff;
         end
         ST_BURST: begin
            // advance the ring so the next character sits in cell zero
            if (rsp_fire) cell_cmd.op = CELL_ROTATE;
         end
         default: begin
            cell_cmd.op = CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         field_len_ff <= FLEN_W'(MAX_LEN);
         keypunch_ff  <= 1'b0;
         upper_ff     <= 1'b0;
         cursor_ff    <= '0;
         clear_ff     <= 1'b0;
         start_ff     <= '0;
         blank_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         clear_ff  <= clear_in;
         start_ff  <= start_in;
         blank_ff  <= blank_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FIELD_LEN: field_len_ff <= csr_wdata[FLEN_W-1:0];
               CSR_KEYPUNCH:  keypunch_ff  <= csr_wdata[0];
               CSR_UPPER:     upper_ff     <= csr_wdata[0];
               default:       keypunch_ff  <= keypunch_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      bell_ff <= bell_in;
      code_ff <= code_in;
      cnt_ff  <= cnt_in;
      ptr_ff  <= ptr_in;
      lo_ff   <= lo_in;
   end

   `ASSERT_HOLDS(a_no_overlap, clock, reset, req_if.ready, !rsp_if.valid, "request taken while a result word is pending")
   `ASSERT_HOLDS(a_cursor_clamped, clock, reset, (state_ff != ST_IDLE), (cursor_ff <= len), "cursor beyond field while busy")
   `ASSERT_HOLDS(a_shift_count, clock, reset, (state_ff == ST_SHIFT), (cnt_ff != '0), "shift pass with zero count")
   `ASSERT_NEXT(a_burst_ends, clock, reset, (rsp_fire && rsp_if.edit_done && rsp_if.last_result), (state_ff == ST_IDLE), "burst did not return to idle")

endmodule

`default_nettype wire
